// ----- src/spc_pkg.sv -----
// Shared types and codes for the simple path counter.
// Depends on nothing; the other files in src, spc_ram aside, refer to it by scoped names.
package spc_pkg;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    localparam logic [4:0] VCOUNT_RESET = 5'd16;

    typedef struct packed {
        logic [1:0] cmd;
        logic [3:0] src_vertex;
        logic [3:0] dst_vertex;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] paths_found;
        logic        count_saturated;
        logic        bad_vertex;
    } t_out_beat;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LATCH,
        DP_EDGE_RD,
        DP_EDGE_WR,
        DP_CLEAR,
        DP_BAD,
        DP_TRIVIAL,
        DP_ROOT,
        DP_LOAD,
        DP_COUNT,
        DP_SAT,
        DP_SKIP,
        DP_PUSH,
        DP_POP,
        DP_LOAD_POP,
        DP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic vertex_ok;
        logic same_vertex;
        logic mask_empty;
        logic next_is_dst;
        logic tally_max;
        logic depth_one;
        logic depth_full;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- src/spc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module spc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/spc_datapath.sv -----
// Datapath: adjacency RAM with row valid bits, backtracking stack RAM,
// walk registers, tally and result register. Uses spc_pkg and spc_ram.
module spc_datapath #(
    parameter int MAX_VERTICES = 16,
    parameter int COUNT_BITS   = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spc_pkg::t_dp_cmd    i_cmd,
    output spc_pkg::t_dp_stat   o_stat,
    input  spc_pkg::t_in_beat   i_in_beat,
    input  logic                i_cfg_we,
    input  logic [4:0]          i_cfg_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output spc_pkg::t_out_beat  o_out_beat
);

    localparam int MV   = MAX_VERTICES;
    localparam int VW   = $clog2(MV);
    localparam int DEPW = $clog2(MV + 1);
    localparam int SW   = VW + MV;

    logic [4:0]            r_vc,        n_vc;
    logic [3:0]            r_src,       n_src;
    logic [3:0]            r_dst,       n_dst;
    logic [MV-1:0]         r_visited,   n_visited;
    logic [DEPW-1:0]       r_depth,     n_depth;
    logic [VW-1:0]         r_top_vtx,   n_top_vtx;
    logic [MV-1:0]         r_top_pend,  n_top_pend;
    logic [COUNT_BITS-1:0] r_tally,     n_tally;
    logic                  r_sat,       n_sat;
    logic                  r_bad,       n_bad;
    logic [MV-1:0]         r_row_vld,   n_row_vld;
    logic                  r_rd_vld;
    logic                  r_out_valid, n_out_valid;
    spc_pkg::t_out_beat    r_out_beat,  n_out_beat;

    logic [VW-1:0]         src_v;
    logic [VW-1:0]         dst_v;
    logic                  src_ok;
    logic                  dst_ok;
    logic [MV-1:0]         in_use;
    logic [MV-1:0]         mask;
    logic [MV-1:0]         lowbit;
    logic [VW-1:0]         next_idx;
    logic [MV-1:0]         row_use;
    logic [COUNT_BITS+31:0] tally_ext;
    logic [DEPW-1:0]       depth_dec;
    logic [DEPW-1:0]       depth_dec2;

    logic                  adj_we;
    logic [VW-1:0]         adj_raddr;
    logic [MV-1:0]         adj_wdata;
    logic [MV-1:0]         adj_rdata;
    logic                  stk_we;
    logic [SW-1:0]         stk_wdata;
    logic [SW-1:0]         stk_rdata;

    assign src_v  = VW'(r_src);
    assign dst_v  = VW'(r_dst);
    assign src_ok = (32'(r_src) < 32'(r_vc)) && (32'(r_src) < MV);
    assign dst_ok = (32'(r_dst) < 32'(r_vc)) && (32'(r_dst) < MV);

    always_comb begin
        for (int i = 0; i < MV; i++) begin
            in_use[i] = (i < 32'(r_vc));
        end
    end

    assign mask   = r_top_pend & ~r_visited;
    assign lowbit = mask & (~mask + 1'b1);

    always_comb begin
        next_idx = '0;
        for (int i = 0; i < MV; i++) begin
            if (lowbit[i]) begin
                next_idx = next_idx | VW'(i);
            end
        end
    end

    assign row_use    = r_rd_vld ? adj_rdata : '0;
    assign tally_ext  = {32'd0, r_tally};
    assign depth_dec  = r_depth - DEPW'(1);
    assign depth_dec2 = r_depth - DEPW'(2);

    assign adj_we    = (i_cmd.op == spc_pkg::DP_EDGE_WR);
    assign adj_raddr = (i_cmd.op == spc_pkg::DP_PUSH) ? next_idx : src_v;
    assign adj_wdata = row_use | (MV'(1) << dst_v);
    assign stk_we    = (i_cmd.op == spc_pkg::DP_PUSH);
    assign stk_wdata = {r_top_vtx, r_top_pend & ~lowbit};

    spc_ram #(
        .WIDTH (MV),
        .DEPTH (MV)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (src_v),
        .i_wdata (adj_wdata),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    spc_ram #(
        .WIDTH (SW),
        .DEPTH (MV)
    ) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (depth_dec[VW-1:0]),
        .i_wdata (stk_wdata),
        .i_raddr (depth_dec2[VW-1:0]),
        .o_rdata (stk_rdata)
    );

    always_comb begin
        n_vc        = i_cfg_we ? i_cfg_data : r_vc;
        n_src       = r_src;
        n_dst       = r_dst;
        n_visited   = r_visited;
        n_depth     = r_depth;
        n_top_vtx   = r_top_vtx;
        n_top_pend  = r_top_pend;
        n_tally     = r_tally;
        n_sat       = r_sat;
        n_bad       = r_bad;
        n_row_vld   = r_row_vld;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_beat  = r_out_beat;
        unique case (i_cmd.op)
            spc_pkg::DP_LATCH: begin
                n_src = i_in_beat.src_vertex;
                n_dst = i_in_beat.dst_vertex;
            end
            spc_pkg::DP_EDGE_WR: begin
                n_row_vld[src_v] = 1'b1;
            end
            spc_pkg::DP_CLEAR: begin
                n_row_vld = '0;
            end
            spc_pkg::DP_BAD: begin
                n_tally = '0;
                n_sat   = 1'b0;
                n_bad   = 1'b1;
            end
            spc_pkg::DP_TRIVIAL: begin
                n_tally = COUNT_BITS'(1);
                n_sat   = 1'b0;
                n_bad   = 1'b0;
            end
            spc_pkg::DP_ROOT: begin
                n_tally   = '0;
                n_sat     = 1'b0;
                n_bad     = 1'b0;
                n_visited = MV'(1) << src_v;
                n_depth   = DEPW'(1);
                n_top_vtx = src_v;
            end
            spc_pkg::DP_LOAD: begin
                n_top_pend = row_use & in_use;
            end
            spc_pkg::DP_COUNT: begin
                n_tally    = r_tally + COUNT_BITS'(1);
                n_top_pend = r_top_pend & ~lowbit;
            end
            spc_pkg::DP_SAT: begin
                n_sat = 1'b1;
            end
            spc_pkg::DP_SKIP: begin
                n_top_pend = r_top_pend & ~lowbit;
            end
            spc_pkg::DP_PUSH: begin
                n_visited = r_visited | lowbit;
                n_top_vtx = next_idx;
                n_depth   = r_depth + DEPW'(1);
            end
            spc_pkg::DP_POP: begin
                n_visited = r_visited & ~(MV'(1) << r_top_vtx);
                n_depth   = depth_dec;
            end
            spc_pkg::DP_LOAD_POP: begin
                n_top_vtx  = stk_rdata[SW-1:MV];
                n_top_pend = stk_rdata[MV-1:0];
            end
            spc_pkg::DP_EMIT: begin
                n_out_valid                = 1'b1;
                n_out_beat.paths_found     = tally_ext[31:0];
                n_out_beat.count_saturated = r_sat;
                n_out_beat.bad_vertex      = r_bad;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc        <= spc_pkg::VCOUNT_RESET;
            r_visited   <= '0;
            r_depth     <= '0;
            r_tally     <= '0;
            r_row_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_vc        <= n_vc;
            r_visited   <= n_visited;
            r_depth     <= n_depth;
            r_tally     <= n_tally;
            r_row_vld   <= n_row_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src      <= n_src;
        r_dst      <= n_dst;
        r_top_vtx  <= n_top_vtx;
        r_top_pend <= n_top_pend;
        r_sat      <= n_sat;
        r_bad      <= n_bad;
        r_rd_vld   <= r_row_vld[adj_raddr];
        r_out_beat <= n_out_beat;
    end

    assign o_stat.vertex_ok   = src_ok && dst_ok;
    assign o_stat.same_vertex = (r_src == r_dst);
    assign o_stat.mask_empty  = (mask == '0);
    assign o_stat.next_is_dst = (next_idx == dst_v);
    assign o_stat.tally_max   = &r_tally;
    assign o_stat.depth_one   = (r_depth == DEPW'(1));
    assign o_stat.depth_full  = (r_depth == DEPW'(MV));
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

// ----- src/spc_ctrl.sv -----
// Controller: sequences edge loads, clears and the backtracking walk.
// Uses spc_pkg; drives the datapath by command and reads its status.
module spc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_in_cmd,
    input  spc_pkg::t_dp_stat  i_stat,
    output spc_pkg::t_dp_cmd   o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_EDGE_RD = 4'd1;
    localparam logic [3:0] S_EDGE_WR = 4'd2;
    localparam logic [3:0] S_CLEAR   = 4'd3;
    localparam logic [3:0] S_QUERY   = 4'd4;
    localparam logic [3:0] S_LOAD    = 4'd5;
    localparam logic [3:0] S_STEP    = 4'd6;
    localparam logic [3:0] S_POP     = 4'd7;
    localparam logic [3:0] S_FINISH  = 4'd8;

    logic [3:0] r_state, n_state;

    always_comb begin
        n_state  = r_state;
        o_cmd.op = spc_pkg::DP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_cmd)
                        spc_pkg::CMD_ADD: begin
                            o_cmd.op = spc_pkg::DP_LATCH;
                            n_state  = S_EDGE_RD;
                        end
                        spc_pkg::CMD_QUERY: begin
                            o_cmd.op = spc_pkg::DP_LATCH;
                            n_state  = S_QUERY;
                        end
                        spc_pkg::CMD_CLEAR: begin
                            n_state = S_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_EDGE_RD: begin
                if (i_stat.vertex_ok) begin
                    o_cmd.op = spc_pkg::DP_EDGE_RD;
                    n_state  = S_EDGE_WR;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EDGE_WR: begin
                o_cmd.op = spc_pkg::DP_EDGE_WR;
                n_state  = S_IDLE;
            end
            S_CLEAR: begin
                o_cmd.op = spc_pkg::DP_CLEAR;
                n_state  = S_IDLE;
            end
            S_QUERY: begin
                if (!i_stat.vertex_ok) begin
                    o_cmd.op = spc_pkg::DP_BAD;
                    n_state  = S_FINISH;
                end else if (i_stat.same_vertex) begin
                    o_cmd.op = spc_pkg::DP_TRIVIAL;
                    n_state  = S_FINISH;
                end else begin
                    o_cmd.op = spc_pkg::DP_ROOT;
                    n_state  = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.op = spc_pkg::DP_LOAD;
                n_state  = S_STEP;
            end
            S_STEP: begin
                if (i_stat.mask_empty) begin
                    o_cmd.op = spc_pkg::DP_POP;
                    n_state  = i_stat.depth_one ? S_FINISH : S_POP;
                end else if (i_stat.next_is_dst) begin
                    if (i_stat.tally_max) begin
                        o_cmd.op = spc_pkg::DP_SAT;
                        n_state  = S_FINISH;
                    end else begin
                        o_cmd.op = spc_pkg::DP_COUNT;
                    end
                end else if (i_stat.depth_full) begin
                    o_cmd.op = spc_pkg::DP_SKIP;
                end else begin
                    o_cmd.op = spc_pkg::DP_PUSH;
                    n_state  = S_LOAD;
                end
            end
            S_POP: begin
                o_cmd.op = spc_pkg::DP_LOAD_POP;
                n_state  = S_STEP;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.op = spc_pkg::DP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ----- src/simple_path_counter_unit.sv -----
// Top level of the simple path counter: controller plus datapath.
// Uses spc_pkg, spc_ctrl, spc_datapath (which holds two spc_ram instances).
//
//   channel   handshake                 payload
//   in        i_in_valid / o_in_ready   i_in_beat  (cmd, src_vertex, dst_vertex)
//   out       o_out_valid / i_out_ready o_out_beat (paths_found, count_saturated,
//                                                   bad_vertex)
//   cfg       i_cfg_we                  i_cfg_data (vertex_count)
//
// Add edge: latch, adjacency read, row write; an out-of-range vertex skips the
// read and write. Clear: a single clear command. Unused command: no beat.
// Query: the walk loop of tallies, skipped neighbors, pushes and pops runs
// around the registered adjacency and stack RAM reads.
// Clear drops all rows at once through per-row valid bits; no sweep after reset.
// A finished result sits in the output register; the next beat is taken while
// it waits, and a later query holds its result until the register frees up.
module simple_path_counter_unit #(
    parameter int MAX_VERTICES = 16,
    parameter int COUNT_BITS   = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  spc_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output spc_pkg::t_out_beat o_out_beat,
    input  logic               i_cfg_we,
    input  logic [4:0]         i_cfg_data
);

    spc_pkg::t_dp_cmd  dp_cmd;
    spc_pkg::t_dp_stat dp_stat;

    spc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_cmd   (i_in_beat.cmd),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    spc_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .COUNT_BITS   (COUNT_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_in_beat   (i_in_beat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for simple_path_counter_unit: loads random and directed graphs,
// asks path-count queries and checks each result beat against a backtracking predictor.
// Depends on spc_pkg and the RTL under src only.
module tb_top;

    localparam int MAX_VERTICES   = 16;
    localparam int COUNT_BITS     = 32;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 200000;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    spc_pkg::t_in_beat  i_in_beat  = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    spc_pkg::t_out_beat o_out_beat;
    logic               i_cfg_we   = 1'b0;
    logic [4:0]         i_cfg_data = '0;

    logic [15:0]        edge_rows [MAX_VERTICES];
    int unsigned        vertex_limit = MAX_VERTICES;
    spc_pkg::t_out_beat expected_counts [$];

    bit idle_on  = 1'b1;
    bit hold_req = 1'b0;
    int hold_left;
    int stall_left;
    int quiet_cycles;
    int fail_count;
    int beats_taken;
    int counts_checked;
    int rejections;
    int settings_used;

    simple_path_counter_unit #(
        .MAX_VERTICES(MAX_VERTICES),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_beat  (i_in_beat),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_beat (o_out_beat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic spc_pkg::t_out_beat predict_paths(input logic [3:0] src,
                                                         input logic [3:0] dst);
        logic [16:0]           span;
        logic [15:0]           in_use;
        logic [15:0]           visited;
        logic [15:0]           open_nbrs;
        logic [15:0]           pending [MAX_VERTICES];
        logic [3:0]            on_path [MAX_VERTICES];
        logic [COUNT_BITS-1:0] tally;
        int                    depth;
        int                    top;
        int                    nxt;
        spc_pkg::t_out_beat    res;
        res = '0;
        if (src >= vertex_limit || dst >= vertex_limit) begin
            res.bad_vertex = 1'b1;
            return res;
        end
        if (src == dst) begin
            res.paths_found = 32'd1;
            return res;
        end
        span       = (17'd1 << vertex_limit) - 17'd1;
        in_use     = span[15:0];
        tally      = '0;
        visited    = 16'd1 << src;
        on_path[0] = src;
        pending[0] = edge_rows[src] & in_use;
        depth      = 1;
        while (depth > 0) begin
            top       = depth - 1;
            open_nbrs = pending[top] & ~visited;
            if (open_nbrs == '0) begin
                // backtrack
                visited[on_path[top]] = 1'b0;
                depth--;
            end else begin
                nxt = 0;
                while (!open_nbrs[nxt]) nxt++;
                pending[top][nxt] = 1'b0;
                if (nxt == dst) begin
                    if (&tally) begin
                        res.paths_found     = 32'(tally);
                        res.count_saturated = 1'b1;
                        return res;
                    end
                    tally++;
                end else if (depth < MAX_VERTICES) begin
                    visited[nxt]   = 1'b1;
                    on_path[depth] = 4'(nxt);
                    pending[depth] = edge_rows[nxt] & in_use;
                    depth++;
                end
            end
        end
        res.paths_found = 32'(tally);
        return res;
    endfunction

    function automatic void apply_beat(input spc_pkg::t_in_beat beat);
        spc_pkg::t_out_beat res;
        beats_taken++;
        case (beat.cmd)
            spc_pkg::CMD_ADD: begin
                if (beat.src_vertex < vertex_limit && beat.dst_vertex < vertex_limit)
                    edge_rows[beat.src_vertex][beat.dst_vertex] = 1'b1;
            end
            spc_pkg::CMD_CLEAR: begin
                foreach (edge_rows[i]) edge_rows[i] = '0;
            end
            spc_pkg::CMD_QUERY: begin
                res = predict_paths(beat.src_vertex, beat.dst_vertex);
                if (res.bad_vertex) rejections++;
                expected_counts = {expected_counts, res};
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void check_count(input spc_pkg::t_out_beat got);
        spc_pkg::t_out_beat want;
        if (expected_counts.size() == 0) begin
            $error("result beat with no query outstanding: paths_found %0d", got.paths_found);
            fail_count++;
            return;
        end
        want = expected_counts.pop_front();
        counts_checked++;
        if (got.paths_found !== want.paths_found) begin
            $error("paths_found: expected %0d, actual %0d", want.paths_found, got.paths_found);
            fail_count++;
        end
        if (got.count_saturated !== want.count_saturated) begin
            $error("count_saturated: expected %0b, actual %0b",
                   want.count_saturated, got.count_saturated);
            fail_count++;
        end
        if (got.bad_vertex !== want.bad_vertex) begin
            $error("bad_vertex: expected %0b, actual %0b", want.bad_vertex, got.bad_vertex);
            fail_count++;
        end
    endfunction

    function automatic spc_pkg::t_in_beat mk_beat(input logic [1:0] cmd, input int src,
                                                  input int dst);
        spc_pkg::t_in_beat beat;
        beat.cmd        = cmd;
        beat.src_vertex = 4'(src);
        beat.dst_vertex = 4'(dst);
        return beat;
    endfunction

    // result side: check, then pick next cycle's ready
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) check_count(o_out_beat);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
                hold_left--;
            else if (stall_left > 0)
                stall_left--;
            else if (idle_on && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 6);
            i_out_ready <= (hold_left == 0) && (stall_left == 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("no beat moved for %0d cycles", quiet_cycles);
            $display("simple_path_counter_unit regression: fail");
            $finish;
        end
    end

    task automatic send_beat(input spc_pkg::t_in_beat beat);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= beat;
        do @(posedge i_clk); while (!o_in_ready);
        apply_beat(beat);
    endtask

    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (expected_counts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_vertex_count(input logic [4:0] value);
        drain_block();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        vertex_limit = (value > MAX_VERTICES) ? MAX_VERTICES : value;
        settings_used++;
    endtask

    task automatic test_small_graph();
        send_beat(mk_beat(spc_pkg::CMD_QUERY, 0, 0));
        send_beat(mk_beat(spc_pkg::CMD_QUERY, 0, 15));
        send_beat(mk_beat(spc_pkg::CMD_ADD, 0, 1));
        send_beat(mk_beat(spc_pkg::CMD_ADD, 1, 2));
        send_beat(mk_beat(spc_pkg::CMD_ADD, 0, 2));
        send_beat(mk_beat(spc_pkg::CMD_ADD, 2, 15));
        send_beat(mk_beat(spc_pkg::CMD_ADD, 0, 1));
        send_beat(mk_beat(spc_pkg::CMD_ADD, 1, 1));
        send_beat(mk_beat(spc_pkg::CMD_QUERY, 0, 15));
        send_beat(mk_beat(spc_pkg::CMD_QUERY, 15, 0));
        send_beat(mk_beat(spc_pkg::CMD_NONE, 15, 15));
        send_beat(mk_beat(spc_pkg::CMD_ADD, 15, 0));
        send_beat(mk_beat(spc_pkg::CMD_QUERY, 15, 2));
        send_beat(mk_beat(spc_pkg::CMD_CLEAR, 15, 15));
        send_beat(mk_beat(spc_pkg::CMD_QUERY, 0, 15));
    endtask

    task automatic test_vertex_limit();
        send_beat(mk_beat(spc_pkg::CMD_ADD, 0, 9));
        send_beat(mk_beat(spc_pkg::CMD_ADD, 9, 3));
        send_beat(mk_beat(spc_pkg::CMD_ADD, 0, 3));
        set_vertex_count(5'd4);
        send_beat(mk_beat(spc_pkg::CMD_QUERY, 0, 3));
        send_beat(mk_beat(spc_pkg::CMD_ADD, 0, 5));
        send_beat(mk_beat(spc_pkg::CMD_QUERY, 0, 5));
        send_beat(mk_beat(spc_pkg::CMD_QUERY, 5, 0));
        send_beat(mk_beat(spc_pkg::CMD_QUERY, 3, 3));
        set_vertex_count(5'd0);
        send_beat(mk_beat(spc_pkg::CMD_QUERY, 0, 0));
        send_beat(mk_beat(spc_pkg::CMD_ADD, 0, 0));
        set_vertex_count(5'd31);
        send_beat(mk_beat(spc_pkg::CMD_QUERY, 0, 3));
        send_beat(mk_beat(spc_pkg::CMD_QUERY, 15, 15));
        set_vertex_count(5'd1);
        send_beat(mk_beat(spc_pkg::CMD_QUERY, 0, 0));
        send_beat(mk_beat(spc_pkg::CMD_QUERY, 0, 1));
    endtask

    task automatic test_dense_and_deep();
        set_vertex_count(5'd8);
        send_beat(mk_beat(spc_pkg::CMD_CLEAR, 0, 0));
        for (int s = 0; s < 8; s++)
            for (int d = 0; d < 8; d++)
                send_beat(mk_beat(spc_pkg::CMD_ADD, s, d));
        send_beat(mk_beat(spc_pkg::CMD_QUERY, 0, 7));
        send_beat(mk_beat(spc_pkg::CMD_QUERY, 5, 2));
        set_vertex_count(5'd16);
        send_beat(mk_beat(spc_pkg::CMD_CLEAR, 0, 0));
        for (int v = 0; v < 15; v++)
            send_beat(mk_beat(spc_pkg::CMD_ADD, v, v + 1));
        send_beat(mk_beat(spc_pkg::CMD_ADD, 15, 0));
        send_beat(mk_beat(spc_pkg::CMD_QUERY, 0, 15));
        send_beat(mk_beat(spc_pkg::CMD_QUERY, 15, 14));
    endtask

    task automatic test_output_backpressure();
        idle_on = 1'b0;
        set_vertex_count(5'd6);
        send_beat(mk_beat(spc_pkg::CMD_CLEAR, 0, 0));
        send_beat(mk_beat(spc_pkg::CMD_ADD, 0, 1));
        send_beat(mk_beat(spc_pkg::CMD_ADD, 1, 2));
        send_beat(mk_beat(spc_pkg::CMD_ADD, 0, 2));
        send_beat(mk_beat(spc_pkg::CMD_ADD, 2, 3));
        send_beat(mk_beat(spc_pkg::CMD_ADD, 3, 5));
        send_beat(mk_beat(spc_pkg::CMD_ADD, 1, 5));
        send_beat(mk_beat(spc_pkg::CMD_ADD, 0, 5));
        hold_req = 1'b1;
        repeat (40)
            send_beat(mk_beat(spc_pkg::CMD_QUERY, $urandom_range(0, 5),
                              $urandom_range(0, 5)));
        drain_block();
        idle_on = 1'b1;
    endtask

    task automatic test_random_graphs(input int beat_goal, input bit with_idling);
        int         sent;
        int         lim;
        int         pick;
        logic [4:0] vc;
        idle_on = with_idling;
        sent    = 0;
        while (sent < beat_goal) begin
            pick = $urandom_range(0, 19);
            if (pick < 10)
                vc = 5'($urandom_range(2, 8));
            else if (pick < 17)
                vc = 5'($urandom_range(9, 16));
            else if (pick == 17)
                vc = 5'($urandom_range(0, 1));
            else
                vc = 5'($urandom_range(17, 31));
            set_vertex_count(vc);
            lim = vertex_limit;
            repeat ($urandom_range(3, 8)) begin
                // keep the old graph now and then
                if ($urandom_range(0, 4) != 0) begin
                    send_beat(mk_beat(spc_pkg::CMD_CLEAR, $urandom_range(0, 15),
                                      $urandom_range(0, 15)));
                    sent++;
                end
                repeat ($urandom_range(0, lim + lim / 2)) begin
                    if (lim > 0 && $urandom_range(0, 9) != 0) begin
                        send_beat(mk_beat(spc_pkg::CMD_ADD, $urandom_range(0, lim - 1),
                                          $urandom_range(0, lim - 1)));
                        sent++;
                    end else begin
                        send_beat(mk_beat(2'($urandom_range(0, 3)), $urandom_range(0, 15),
                                          $urandom_range(0, 15)));
                    end
                end
                repeat ($urandom_range(1, 8)) begin
                    if (lim > 0 && $urandom_range(0, 7) != 0)
                        send_beat(mk_beat(spc_pkg::CMD_QUERY, $urandom_range(0, lim - 1),
                                          $urandom_range(0, lim - 1)));
                    else
                        send_beat(mk_beat(spc_pkg::CMD_QUERY, $urandom_range(0, 15),
                                          $urandom_range(0, 15)));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        foreach (edge_rows[i]) edge_rows[i] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_small_graph();
        test_vertex_limit();
        test_dense_and_deep();
        test_output_backpressure();
        test_random_graphs(1300, 1'b1);
        test_random_graphs(200, 1'b0);
        drain_block();
        $display("covered %0d input beats over %0d vertex-count settings", beats_taken,
                 settings_used);
        $display("checked %0d path counts, %0d of them out-of-range rejections",
                 counts_checked, rejections);
        if (fail_count == 0)
            $display("simple_path_counter_unit regression: pass");
        else
            $display("simple_path_counter_unit regression: fail");
        $finish;
    end

endmodule
